### src/tfs_pkg.sv
// ----------------------------------------------------------------------------
// tfs_pkg
// Shared types, codes and constants for the typed record field splitter.
// ----------------------------------------------------------------------------
package tfs_pkg;

  localparam int unsigned MAX_FIELDS_DEF  = 16;
  localparam int unsigned OFFSET_BITS_DEF = 32;
  localparam int unsigned LEN_W           = 33;
  localparam int unsigned OFF_OUT_W       = 32;
  localparam int unsigned PREFIX_W        = 32;
  localparam int unsigned COUNT_W         = 5;
  localparam int unsigned TYPES_W         = 64;
  localparam int unsigned APB_DATA_W      = 64;
  localparam int unsigned APB_ADDR_W      = 4;

  typedef enum logic [3:0] {
    KIND_I8    = 4'd0,
    KIND_I16   = 4'd1,
    KIND_U16   = 4'd2,
    KIND_I32   = 4'd3,
    KIND_D64   = 4'd4,
    KIND_MAC   = 4'd5,
    KIND_IPV4  = 4'd6,
    KIND_IPV46 = 4'd7,
    KIND_STR8  = 4'd8,
    KIND_STR   = 4'd9,
    KIND_BLOB  = 4'd10
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TRUNCATED  = 3'd1,
    ST_TRAILING   = 3'd2,
    ST_BAD_PREFIX = 3'd3,
    ST_OVERLONG   = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    REG_FIELD_COUNT = 1'b0,
    REG_FIELD_TYPES = 1'b1
  } reg_e;

  localparam logic [7:0] ADDR_PREFIX_V4 = 8'd4;
  localparam logic [7:0] ADDR_PREFIX_V6 = 8'd16;
  localparam logic [LEN_W-1:0] WIDE_PREFIX_LEN = LEN_W'(4);

  typedef struct packed {
    logic                 emit;
    logic [3:0]           field_index;
    logic [3:0]           field_kind;
    logic [OFF_OUT_W-1:0] field_offset;
    logic [LEN_W-1:0]     field_length;
    logic                 field_valid;
    logic                 record_done;
    status_e              status;
  } result_t;

  function automatic logic [3:0] fixed_len(input logic [3:0] kind);
    logic [3:0] len;
    case (kind) inside
      KIND_I8:                       len = 4'd1;
      KIND_I16, KIND_U16:            len = 4'd2;
      KIND_I32, KIND_IPV4:           len = 4'd4;
      KIND_D64:                      len = 4'd8;
      KIND_MAC:                      len = 4'd6;
      KIND_IPV46, KIND_STR8,
      KIND_STR, KIND_BLOB:           len = 4'd0;
      default:                       len = 4'd1;
    endcase
    return len;
  endfunction

endpackage

### src/tfs_core.sv
// ----------------------------------------------------------------------------
// tfs_core
// Per-record parse state and the single-pass update for one byte item.
// ----------------------------------------------------------------------------
module tfs_core #(
  parameter int unsigned MAX_FIELDS  = tfs_pkg::MAX_FIELDS_DEF,
  parameter int unsigned OFFSET_BITS = tfs_pkg::OFFSET_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  logic [7:0]                        data_byte_i,
  input  logic                              last_byte_i,
  input  logic [tfs_pkg::COUNT_W-1:0]       field_count_i,
  input  logic [tfs_pkg::TYPES_W-1:0]       field_types_i,
  output tfs_pkg::result_t                  res_o
);

  localparam int unsigned CF_W = $clog2(MAX_FIELDS + 1);
  localparam int unsigned LW   = tfs_pkg::LEN_W;
  localparam int unsigned PW   = tfs_pkg::PREFIX_W;

  logic [CF_W-1:0]        cur_field_q, cur_field_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [LW-1:0]          bif_q, bif_d;
  logic [LW-1:0]          need_q, need_d;
  logic [PW-1:0]          pref_q, pref_d;
  tfs_pkg::status_e       err_q, err_d;

  logic [tfs_pkg::COUNT_W-1:0] limit;
  logic [3:0]                  type_sel;
  logic [3:0]                  kind;
  logic                        first;
  logic [LW-1:0]               bif_inc;
  logic                        done;

  assign limit = (field_count_i > tfs_pkg::COUNT_W'(MAX_FIELDS)) ?
                 tfs_pkg::COUNT_W'(MAX_FIELDS) : field_count_i;
  assign type_sel = 4'(cur_field_q);
  assign kind     = field_types_i[{type_sel, 2'b00} +: 4];
  assign first    = (bif_q == '0);
  assign bif_inc  = bif_q + LW'(1);

  always_comb begin
    cur_field_d = cur_field_q;
    pos_d       = pos_q;
    start_d     = start_q;
    bif_d       = bif_q;
    need_d      = need_q;
    pref_d      = pref_q;
    err_d       = err_q;
    done        = 1'b0;
    if (err_q == tfs_pkg::ST_OK) begin
      if (pos_q == '1) begin
        err_d = tfs_pkg::ST_OVERLONG;
      end else if (tfs_pkg::COUNT_W'(cur_field_q) >= limit) begin
        err_d = tfs_pkg::ST_TRAILING;
      end else begin
        if (first) begin
          start_d = pos_q;
          pref_d  = '0;
          need_d  = LW'(tfs_pkg::fixed_len(kind));
        end
        if (kind == tfs_pkg::KIND_IPV46 && first) begin
          if (data_byte_i != tfs_pkg::ADDR_PREFIX_V4 && data_byte_i != tfs_pkg::ADDR_PREFIX_V6)
          begin
            err_d = tfs_pkg::ST_BAD_PREFIX;
          end else begin
            need_d = LW'(data_byte_i) + LW'(1);
          end
        end else if (kind == tfs_pkg::KIND_STR8 && first) begin
          need_d = LW'(data_byte_i) + LW'(1);
        end else if ((kind == tfs_pkg::KIND_STR || kind == tfs_pkg::KIND_BLOB) &&
                     bif_q < LW'(4)) begin
          pref_d[{bif_q[1:0], 3'b000} +: 8] = data_byte_i;
          if (bif_q == LW'(3)) begin
            need_d = tfs_pkg::WIDE_PREFIX_LEN + LW'(pref_d);
          end
        end
        if (err_d == tfs_pkg::ST_OK) begin
          bif_d = bif_inc;
          pos_d = pos_q + OFFSET_BITS'(1);
          if (need_d != '0 && bif_inc == need_d) begin
            done        = 1'b1;
            cur_field_d = cur_field_q + CF_W'(1);
          end
        end
      end
    end
  end

  always_comb begin
    res_o = '0;
    res_o.status = tfs_pkg::ST_OK;
    res_o.emit   = done || last_byte_i;
    if (done) begin
      res_o.field_index  = type_sel;
      res_o.field_kind   = kind;
      res_o.field_offset = tfs_pkg::OFF_OUT_W'(start_d);
      res_o.field_length = need_d;
      res_o.field_valid  = 1'b1;
    end
    if (last_byte_i) begin
      res_o.record_done = 1'b1;
      if (err_d != tfs_pkg::ST_OK) begin
        res_o.status = err_d;
      end else if (tfs_pkg::COUNT_W'(cur_field_d) < limit) begin
        res_o.status = tfs_pkg::ST_TRUNCATED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_field_q <= '0;
      pos_q       <= '0;
      start_q     <= '0;
      bif_q       <= '0;
      need_q      <= '0;
      pref_q      <= '0;
      err_q       <= tfs_pkg::ST_OK;
    end else if (step_i) begin
      if (last_byte_i) begin
        cur_field_q <= '0;
        pos_q       <= '0;
        start_q     <= '0;
        bif_q       <= '0;
        need_q      <= '0;
        pref_q      <= '0;
        err_q       <= tfs_pkg::ST_OK;
      end else begin
        cur_field_q <= cur_field_d;
        pos_q       <= pos_d;
        start_q     <= start_d;
        err_q       <= err_d;
        if (done) begin
          bif_q  <= '0;
          need_q <= '0;
          pref_q <= '0;
        end else begin
          bif_q  <= bif_d;
          need_q <= need_d;
          pref_q <= pref_d;
        end
      end
    end
  end

endmodule

### src/typed_record_field_splitter_unit.sv
// ----------------------------------------------------------------------------
// typed_record_field_splitter_unit
// Splits a byte stream into schema-typed fields and reports record status.
// An accepted item goes from the input register to the output result register.
// Throughput: one byte item per cycle while the result register is not
// stalled; the record state update in between sets this figure.
// Reset: asynchronous, active low; clears handshake, schema and parse state.
// ----------------------------------------------------------------------------
module typed_record_field_splitter_unit #(
  parameter int unsigned MAX_FIELDS  = tfs_pkg::MAX_FIELDS_DEF,
  parameter int unsigned OFFSET_BITS = tfs_pkg::OFFSET_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tfs_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [tfs_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [tfs_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       data_byte_i,
  input  logic                             last_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [3:0]                       field_index_o,
  output logic [3:0]                       field_kind_o,
  output logic [tfs_pkg::OFF_OUT_W-1:0]    field_offset_o,
  output logic [tfs_pkg::LEN_W-1:0]        field_length_o,
  output logic                             field_valid_o,
  output logic                             record_done_o,
  output logic [2:0]                       status_o
);

  logic [tfs_pkg::COUNT_W-1:0] field_count_q;
  logic [tfs_pkg::TYPES_W-1:0] field_types_q;
  logic                        cfg_wr;
  tfs_pkg::reg_e               reg_sel;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       out_free;
  logic       step;

  tfs_pkg::result_t res;
  tfs_pkg::result_t out_q;
  logic             out_valid_q;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = tfs_pkg::reg_e'(paddr[3]);

  always_comb begin
    unique case (reg_sel)
      tfs_pkg::REG_FIELD_COUNT: prdata = tfs_pkg::APB_DATA_W'(field_count_q);
      tfs_pkg::REG_FIELD_TYPES: prdata = field_types_q;
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_count_q <= '0;
      field_types_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        tfs_pkg::REG_FIELD_COUNT: field_count_q <= pwdata[tfs_pkg::COUNT_W-1:0];
        tfs_pkg::REG_FIELD_TYPES: field_types_q <= pwdata;
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && (!res.emit || out_free);
  assign in_stall_o = s1_valid_q && !step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  tfs_core #(
    .MAX_FIELDS  (MAX_FIELDS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .data_byte_i   (s1_byte_q),
    .last_byte_i   (s1_last_q),
    .field_count_i (field_count_q),
    .field_types_i (field_types_q),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign field_index_o  = out_q.field_index;
  assign field_kind_o   = out_q.field_kind;
  assign field_offset_o = out_q.field_offset;
  assign field_length_o = out_q.field_length;
  assign field_valid_o  = out_q.field_valid;
  assign record_done_o  = out_q.record_done;
  assign status_o       = out_q.status;

endmodule

### src/tfs_checker.sv
// ----------------------------------------------------------------------------
// tfs_checker
// Port-level checks on the result channel of the field splitter.
// ----------------------------------------------------------------------------
module tfs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [tfs_pkg::OFF_OUT_W-1:0] field_offset_o,
  input logic [tfs_pkg::LEN_W-1:0]     field_length_o,
  input logic                          field_valid_o,
  input logic                          record_done_o,
  input logic [2:0]                    status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(field_length_o) &&
    $stable(status_o))
    else $error("result item changed while stalled");

  a_out_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> field_valid_o || record_done_o)
    else $error("result item carries neither a field nor an end of record");

  a_status_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !record_done_o |-> status_o == tfs_pkg::ST_OK)
    else $error("status set on a result that does not end the record");

  a_field_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && field_valid_o |-> field_length_o != '0)
    else $error("completed field with zero length");

  a_no_field_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !field_valid_o |-> field_offset_o == '0 && field_length_o == '0)
    else $error("field data present on a result without a field");

endmodule

bind typed_record_field_splitter_unit tfs_checker u_tfs_checker (.*);
